// ===== design/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants for the shaped ramp generator
// Operation and shape codes, register indexes, the microcode word, the
// sequencer program and the quarter-wave sine entry function.
// ----------------------------------------------------------------------------
package srg_pkg;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_LOAD    = 2'd1,
    OP_CHECK   = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SHAPE_LINEAR = 2'd0,
    SHAPE_SINE   = 2'd1,
    SHAPE_QUAD   = 2'd2
  } shape_t;

  localparam logic [0:0] REG_RAMP_LENGTH = 1'b0;
  localparam logic [0:0] REG_CURVE_SHAPE = 1'b1;

  localparam logic [15:0] RAMP_LENGTH_RESET = 16'd1000;
  localparam logic [17:0] ONE_Q16           = 18'd65536;
  localparam logic [63:0] HALF_PI_Q30       = 64'd1686629713;

  // Datapath actions, one per microcode step.
  typedef enum logic [3:0] {
    UOP_IDLE,
    UOP_EXEC,
    UOP_SQ_DIFF,
    UOP_SQ_LEN,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_POST,
    UOP_SINE_MUL,
    UOP_SINE_FIN,
    UOP_EMIT
  } uop_t;

  // SEQ_JUMP: go to target when the condition holds, else fall through.
  // SEQ_WAIT: stay while the condition holds, else go to target.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_WAIT
  } seq_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_DIRECT,
    COND_DIV_MORE,
    COND_NOT_SINE,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_EXEC     = 4'd1;
  localparam step_t STEP_SQ_DIFF  = 4'd2;
  localparam step_t STEP_SQ_LEN   = 4'd3;
  localparam step_t STEP_DIV_INIT = 4'd4;
  localparam step_t STEP_DIV_STEP = 4'd5;
  localparam step_t STEP_POST     = 4'd6;
  localparam step_t STEP_SINE_MUL = 4'd7;
  localparam step_t STEP_SINE_FIN = 4'd8;
  localparam step_t STEP_EMIT     = 4'd9;

  typedef struct packed {
    uop_t  uop;
    seq_t  seq;
    cond_t cond;
    step_t target;
  } srg_ctrl_t;

  typedef struct packed {
    logic no_input;
    logic direct;
    logic div_more;
    logic not_sine;
    logic out_busy;
  } srg_status_t;

  // The sequencer program.
  function automatic srg_ctrl_t microcode(input step_t step);
    srg_ctrl_t w;
    unique case (step)
      STEP_IDLE:     w = '{uop: UOP_IDLE, seq: SEQ_WAIT, cond: COND_NO_INPUT,
                           target: STEP_EXEC};
      STEP_EXEC:     w = '{uop: UOP_EXEC, seq: SEQ_JUMP, cond: COND_DIRECT,
                           target: STEP_EMIT};
      STEP_SQ_DIFF:  w = '{uop: UOP_SQ_DIFF, seq: SEQ_NEXT, cond: COND_NONE,
                           target: STEP_IDLE};
      STEP_SQ_LEN:   w = '{uop: UOP_SQ_LEN, seq: SEQ_NEXT, cond: COND_NONE,
                           target: STEP_IDLE};
      STEP_DIV_INIT: w = '{uop: UOP_DIV_INIT, seq: SEQ_NEXT, cond: COND_NONE,
                           target: STEP_IDLE};
      STEP_DIV_STEP: w = '{uop: UOP_DIV_STEP, seq: SEQ_JUMP, cond: COND_DIV_MORE,
                           target: STEP_DIV_STEP};
      STEP_POST:     w = '{uop: UOP_POST, seq: SEQ_JUMP, cond: COND_NOT_SINE,
                           target: STEP_EMIT};
      STEP_SINE_MUL: w = '{uop: UOP_SINE_MUL, seq: SEQ_NEXT, cond: COND_NONE,
                           target: STEP_IDLE};
      STEP_SINE_FIN: w = '{uop: UOP_SINE_FIN, seq: SEQ_NEXT, cond: COND_NONE,
                           target: STEP_IDLE};
      STEP_EMIT:     w = '{uop: UOP_EMIT, seq: SEQ_WAIT, cond: COND_OUT_BUSY,
                           target: STEP_IDLE};
      default:       w = '{uop: UOP_IDLE, seq: SEQ_NEXT, cond: COND_NONE,
                           target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // sin(pi/2 * idx / 2^tbits) in Q16, from a Taylor series in Q30.
  // Used only to build the constant table at elaboration.
  function automatic logic [16:0] sine_entry(input int unsigned idx,
                                             input int unsigned tbits);
    logic [63:0] ang;
    logic [63:0] a2;
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    ang  = (HALF_PI_Q30 * 64'(idx)) >> tbits;
    a2   = (ang * ang) >> 30;
    sum  = ang;
    term = ang;
    for (k = 1; k <= 7; k++) begin
      term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd8192) >> 14;
    if (sum > 64'd65536) begin
      sum = 64'd65536;
    end
    return sum[16:0];
  endfunction

endpackage

// ===== design/srg_sequencer.sv =====
// ----------------------------------------------------------------------------
// srg_sequencer: microcode step counter for the shaped ramp generator
// Holds the step counter, reads the control word from the program table and
// picks the next step from the datapath status.
// ----------------------------------------------------------------------------
module srg_sequencer
  import srg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  srg_status_t status,
  output srg_ctrl_t   ctrl
);

  step_t pc;
  step_t pc_next;
  logic  cond_true;

  assign ctrl = microcode(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:     cond_true = 1'b0;
      COND_NO_INPUT: cond_true = status.no_input;
      COND_DIRECT:   cond_true = status.direct;
      COND_DIV_MORE: cond_true = status.div_more;
      COND_NOT_SINE: cond_true = status.not_sine;
      COND_OUT_BUSY: cond_true = status.out_busy;
      default:       cond_true = 1'b0;
    endcase

    unique case (ctrl.seq)
      SEQ_NEXT: pc_next = pc + step_t'(1);
      SEQ_JUMP: pc_next = cond_true ? ctrl.target : pc + step_t'(1);
      SEQ_WAIT: pc_next = cond_true ? pc : ctrl.target;
      default:  pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== design/shaped_ramp_generator.sv =====
// ----------------------------------------------------------------------------
// shaped_ramp_generator: progress ramp with linear, sine or quadratic shaping
// A microcoded sequencer drives a datapath with one shared multiplier and a
// one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Load, check and restart, and
// an advance that reaches the ramp length, go from the execute step straight
// to the emit step. A shaped advance runs the divider one quotient bit per
// cycle, then the post step; the sine shape then runs the sine multiply and
// finish steps before the emit step. A finished result waits in the output
// register while the next transaction is taken and worked on. The user must
// write configuration only while idle; the block itself does not enforce it.
module shaped_ramp_generator
  import srg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 8,
  parameter int COUNT_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // step_amount[15:0], load_value[31:16]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // ramp_value[17:0], done_flag[18], zero
);

  localparam int QUARTER = 1 << SINE_TABLE_BITS;
  localparam int KW      = SINE_TABLE_BITS + 1;
  localparam int QW      = SINE_TABLE_BITS + 19;
  localparam int LW      = $clog2(QW);
  localparam int SUM_W   = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int SHIFT_LIN  = 16;
  localparam int SHIFT_QUAD = 17;
  localparam int SHIFT_SINE = SINE_TABLE_BITS + 18;

  srg_ctrl_t   ctrl;
  srg_status_t status;

  // Configuration and state.
  logic [15:0]           ramp_length;
  logic [1:0]            curve_shape;
  logic [COUNT_BITS-1:0] progress_count;
  logic                  done_sticky;

  // Captured transaction.
  op_t         op_reg;
  logic [15:0] step_reg;
  logic [15:0] load_reg;

  // Datapath registers.
  logic [15:0]   shape_num;
  logic [17:0]   value;
  logic [31:0]   sq_diff;
  logic [31:0]   sq_len;
  logic [32:0]   interp_prod;
  logic [31:0]   div_den;
  logic [31:0]   div_rem;
  logic [QW-1:0] div_quo;
  logic [LW-1:0] div_left;
  logic [16:0]   sine_a;
  logic [16:0]   sine_b;
  logic [15:0]   sine_frac;
  logic          sine_neg;
  logic          sine_up;

  // Output register.
  logic        out_valid;
  logic [17:0] ramp_out;
  logic        done_out;

  logic [16:0] sine_rom [QUARTER+1];

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_sine
    localparam logic [16:0] ENTRY = sine_entry(gi, SINE_TABLE_BITS);
    assign sine_rom[gi] = ENTRY;
  end

  srg_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Combinational datapath.
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      len_ext;
  logic [SUM_W-1:0]      cnt_ext;
  logic                  reach;
  logic [COUNT_BITS-1:0] sum_cnt;
  logic [15:0]           diff_d;
  logic [16:0]           mul_a;
  logic [15:0]           mul_b;
  logic [32:0]           mul_p;
  logic [16:0]           interp_diff;
  logic                  b_ge_a;
  logic [32:0]           rem2;
  logic                  rem_ge;
  logic [32:0]           rem_sub;
  logic [31:0]           init_num;
  logic [31:0]           init_den;
  logic [LW-1:0]         init_shift;
  logic [1:0]            quad;
  logic [SINE_TABLE_BITS-1:0] sine_j;
  logic [KW-1:0]         k0;
  logic [KW-1:0]         k1;
  logic [16:0]           corr;
  logic [16:0]           mag;

  assign sum     = SUM_W'(progress_count) + SUM_W'(step_reg);
  assign len_ext = SUM_W'(ramp_length);
  assign cnt_ext = SUM_W'(progress_count);
  assign reach   = sum >= len_ext;
  assign sum_cnt = COUNT_BITS'(sum);
  assign diff_d  = ramp_length - shape_num;

  assign b_ge_a      = sine_b >= sine_a;
  assign interp_diff = b_ge_a ? (sine_b - sine_a) : (sine_a - sine_b);

  always_comb begin
    unique case (ctrl.uop)
      UOP_SQ_DIFF: begin
        mul_a = 17'(diff_d);
        mul_b = diff_d;
      end
      UOP_SQ_LEN: begin
        mul_a = 17'(ramp_length);
        mul_b = ramp_length;
      end
      default: begin
        mul_a = interp_diff;
        mul_b = sine_frac;
      end
    endcase
  end

  assign mul_p = 33'(mul_a) * 33'(mul_b);

  assign rem2    = {div_rem, 1'b0};
  assign rem_ge  = rem2 >= {1'b0, div_den};
  assign rem_sub = rem2 - {1'b0, div_den};

  always_comb begin
    unique case (curve_shape)
      SHAPE_SINE: begin
        init_num   = 32'(shape_num);
        init_den   = 32'(ramp_length);
        init_shift = LW'(SHIFT_SINE);
      end
      SHAPE_QUAD: begin
        init_num   = sq_diff;
        init_den   = sq_len;
        init_shift = LW'(SHIFT_QUAD);
      end
      default: begin
        init_num   = 32'(shape_num);
        init_den   = 32'(ramp_length);
        init_shift = LW'(SHIFT_LIN);
      end
    endcase
  end

  // Phase split: quadrant, table step and interpolation fraction.
  assign quad   = div_quo[SINE_TABLE_BITS+17:SINE_TABLE_BITS+16];
  assign sine_j = div_quo[SINE_TABLE_BITS+15:16];
  assign k0     = quad[0] ? (KW'(QUARTER) - KW'(sine_j)) : KW'(sine_j);
  assign k1     = quad[0] ? (k0 - KW'(1)) : (k0 + KW'(1));

  assign corr = interp_prod[32:16];
  assign mag  = sine_up ? (sine_a + corr) : (sine_a - corr);

  assign status.no_input = !s_axis_tvalid;
  assign status.direct   = (op_reg != OP_ADVANCE) || reach;
  assign status.div_more = div_left != LW'(1);
  assign status.not_sine = curve_shape != SHAPE_SINE;
  assign status.out_busy = out_valid && !m_axis_tready;

  assign s_axis_tready = ctrl.uop == UOP_IDLE;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_length    <= RAMP_LENGTH_RESET;
      curve_shape    <= SHAPE_LINEAR;
      progress_count <= '0;
      done_sticky    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RAMP_LENGTH: ramp_length <= cfg_data;
          REG_CURVE_SHAPE: curve_shape <= cfg_data[1:0];
          default:         ramp_length <= ramp_length;
        endcase
      end

      if (ctrl.uop == UOP_EXEC) begin
        unique case (op_reg)
          OP_ADVANCE: begin
            if (reach) begin
              progress_count <= COUNT_BITS'(ramp_length);
              done_sticky    <= 1'b1;
            end else begin
              progress_count <= sum_cnt;
            end
          end
          OP_LOAD: progress_count <= COUNT_BITS'(load_reg);
          OP_CHECK: begin
            if (cnt_ext >= len_ext) begin
              progress_count <= COUNT_BITS'(ramp_length);
              done_sticky    <= 1'b1;
            end
          end
          OP_RESTART: begin
            progress_count <= '0;
            done_sticky    <= 1'b0;
          end
          default: progress_count <= progress_count;
        endcase
      end

      if (ctrl.uop == UOP_EMIT && !status.out_busy) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.uop == UOP_IDLE && s_axis_tvalid) begin
      op_reg   <= op_t'(s_axis_tuser);
      step_reg <= s_axis_tdata[15:0];
      load_reg <= s_axis_tdata[31:16];
    end

    unique case (ctrl.uop)
      UOP_EXEC: begin
        value     <= (op_reg == OP_ADVANCE) ? ONE_Q16 : '0;
        shape_num <= 16'(sum_cnt);
      end
      UOP_SQ_DIFF: sq_diff <= mul_p[31:0];
      UOP_SQ_LEN:  sq_len  <= mul_p[31:0];
      UOP_DIV_INIT: begin
        // The integer part is at most one, since the numerator never
        // exceeds the divisor.
        div_den  <= init_den;
        div_left <= init_shift;
        if (init_num >= init_den) begin
          div_rem <= init_num - init_den;
          div_quo <= QW'(1);
        end else begin
          div_rem <= init_num;
          div_quo <= '0;
        end
      end
      UOP_DIV_STEP: begin
        div_left <= div_left - LW'(1);
        if (rem_ge) begin
          div_rem <= rem_sub[31:0];
          div_quo <= {div_quo[QW-2:0], 1'b1};
        end else begin
          div_rem <= rem2[31:0];
          div_quo <= {div_quo[QW-2:0], 1'b0};
        end
      end
      UOP_POST: begin
        if (curve_shape == SHAPE_QUAD) begin
          value <= ONE_Q16 - div_quo[17:0];
        end else begin
          value <= 18'(div_quo[15:0]);
        end
        sine_a    <= sine_rom[k0];
        sine_b    <= sine_rom[k1];
        sine_frac <= div_quo[15:0];
        sine_neg  <= quad[1];
      end
      UOP_SINE_MUL: begin
        interp_prod <= mul_p;
        sine_up     <= b_ge_a;
      end
      UOP_SINE_FIN: value <= sine_neg ? (18'(0) - 18'(mag)) : 18'(mag);
      UOP_EMIT: begin
        if (!status.out_busy) begin
          ramp_out <= value;
          done_out <= done_sticky;
        end
      end
      default: value <= value;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, done_out, ramp_out};

  // The sticky flag only falls on a restart.
  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(done_sticky) |-> $past(ctrl.uop == UOP_EXEC && op_reg == OP_RESTART))
    else $error("done flag cleared without a restart");

  a_count_clamped: assert property (@(posedge clk) disable iff (rst)
    (ctrl.uop == UOP_EXEC && op_reg == OP_ADVANCE) |=> (cnt_ext <= len_ext))
    else $error("count above ramp length after advance");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (ctrl.uop == UOP_DIV_STEP) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(ctrl.uop == UOP_EMIT))
    else $error("result presented outside the emit step");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.uop == UOP_EMIT) |->
      ($signed(value) <= 18'sd65536 && $signed(value) >= -18'sd65536))
    else $error("ramp value out of Q1.16 range");

endmodule
